// ===== rtl/assert_macros.svh =====
// Assertion macros used by the binary-lifting LCA engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, ignored while rst_n is low.
`define BL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger on one edge, check the consequent on the next edge.
`define BL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/bllca_pkg.sv =====
// Shared types and constants of the binary-lifting LCA engine.
package bllca_pkg;

    localparam int NODE_W      = 10;   // node number on the ports
    localparam int DEPTH_W     = 11;   // stored depth
    localparam int DSUM_W      = 18;   // depth plus largest jump span
    localparam int SHIFT_W     = 5;    // jump level as a shift count
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd2047;

    typedef enum logic [1:0] {
        STEP_ORDER = 2'd0,   // hit when depth u < depth v
        STEP_LIFT  = 2'd1,   // hit when depth u >= depth v + 2^level
        STEP_CLIMB = 2'd2    // hit when the two ancestors differ
    } step_mode_t;

    typedef struct packed {
        step_mode_t         mode;
        logic [SHIFT_W-1:0] shift;
    } step_ctl_t;

endpackage

// ===== rtl/bllca_ram.sv =====
// Two-read one-write table with registered reads, write-first and node-0 forcing.
module bllca_ram #(
    parameter int AW    = 10,
    parameter int WIDTH = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic             rd_zero_a,
    input  logic [AW-1:0]    rd_addr_b,
    input  logic             rd_zero_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_a_reg;
    logic [WIDTH-1:0] q_b_reg;
    logic             zero_a_reg;
    logic             zero_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // same-edge write to the read address is passed straight through
        if (wr_en && (wr_addr == rd_addr_a))
        begin
            q_a_reg <= wr_data;
        end
        else
        begin
            q_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b))
        begin
            q_b_reg <= wr_data;
        end
        else
        begin
            q_b_reg <= mem[rd_addr_b];
        end
        zero_a_reg <= rd_zero_a;
        zero_b_reg <= rd_zero_b;
    end

    // sentinel row: node 0 always reads as zero
    assign rd_data_a = zero_a_reg ? '0 : q_a_reg;
    assign rd_data_b = zero_b_reg ? '0 : q_b_reg;

endmodule

// ===== rtl/bllca_step_unit.sv =====
// Shared compare unit: depth order, lift test and ancestor mismatch.
module bllca_step_unit (
    input  bllca_pkg::step_ctl_t                 ctl,
    input  logic [bllca_pkg::DEPTH_W-1:0]        du,
    input  logic [bllca_pkg::DEPTH_W-1:0]        dv,
    input  logic [bllca_pkg::NODE_W-1:0]         ju,
    input  logic [bllca_pkg::NODE_W-1:0]         jv,
    output logic                                 hit
);

    localparam int DW = bllca_pkg::DSUM_W;

    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic          ge;
    logic          eq;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctl.mode)
            bllca_pkg::STEP_ORDER:
            begin
                op_a = DW'(du);
                op_b = DW'(dv);
            end
            bllca_pkg::STEP_LIFT:
            begin
                op_a = DW'(du);
                op_b = DW'(dv) + (DW'(1) << ctl.shift);
            end
            bllca_pkg::STEP_CLIMB:
            begin
                op_a = DW'(ju);
                op_b = DW'(jv);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign ge = (op_a >= op_b);
    assign eq = (op_a == op_b);

    always_comb
    begin
        unique case (ctl.mode)
            bllca_pkg::STEP_ORDER: hit = !ge;
            bllca_pkg::STEP_LIFT:  hit = ge;
            bllca_pkg::STEP_CLIMB: hit = !eq;
            default:               hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/binary_lifting_lca_engine_core.sv =====
// Top level of the binary-lifting LCA engine: sequencer, tables and result register.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  s_axis  | in  | tdata: node_a [9:0], node_b [19:10]; tuser: func (0 add, 1 query)
//  m_axis  | out | tdata: ancestor [9:0]; one beat per query, none per add
//
//  Add: accept, then depth and level 0, then one step per further level.
//  Query: accept, depth order, one lift step and one climb step per level, final
//  read; each step is one registered read of the jump table.
//  The climb pass is skipped when lifting lands on the other node.
//  An add that names node 0 or a node at or above MAX_NODES is accepted and dropped.
//  Reset clears control only; tables hold no reset and need no clearing pass.
//  A query that finishes while the result register is full and not taken waits
//  in its final step; s_axis is taken again once the result is loaded.
`include "assert_macros.svh"

module binary_lifting_lca_engine_core #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata from bit 0: node_a[9:0], node_b[19:10], zero [23:20]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // s_axis_tuser from bit 0: func
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // m_axis_tdata from bit 0: ancestor[9:0], zero [15:10]
    output logic [15:0] m_axis_tdata
);

    localparam int NW    = bllca_pkg::NODE_W;
    localparam int DPW   = bllca_pkg::DEPTH_W;
    localparam int SW    = bllca_pkg::SHIFT_W;
    localparam int OW    = bllca_pkg::OUT_TDATA_W;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LVL_W = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int JAW   = IDX_W + LVL_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(JUMP_LEVELS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ADD0  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_SWAP  = 7'b0001000,
        S_LIFT  = 7'b0010000,
        S_CLIMB = 7'b0100000,
        S_FINAL = 7'b1000000
    } state_t;

    // out-of-range node numbers fold to the sentinel
    function automatic logic [IDX_W-1:0] clamp_node(input logic [NW-1:0] x);
        if (32'(x) < MAX_NODES)
        begin
            return IDX_W'(x);
        end
        return '0;
    endfunction

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    u_reg, u_next;      // first walker, also mid node of an add
    logic [IDX_W-1:0]    v_reg, v_next;      // second walker
    logic [IDX_W-1:0]    x_reg, x_next;      // node being added
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [DPW-1:0]      dv_reg, dv_next;    // depth of the shallower node
    logic                eq_reg, eq_next;    // walkers met after lifting
    logic                out_valid_reg, out_valid_next;
    logic [NW-1:0]       out_data_reg;

    logic                in_func;
    logic [NW-1:0]       in_a;
    logic [NW-1:0]       in_b;
    logic                add_ok;
    logic [IDX_W-1:0]    lift_u;

    logic [NW-1:0]       ju, jv;
    logic [DPW-1:0]      du, dv;
    logic [DPW-1:0]      dv_cmp;
    logic                jw_en, dw_en;
    logic [LVL_W-1:0]    jw_lvl;
    logic [NW-1:0]       jw_data;
    logic [DPW-1:0]      dw_data;

    bllca_pkg::step_ctl_t step_ctl;
    logic                 step_hit;

    logic                res_load;
    logic [NW-1:0]       res_data;
    logic                out_free;

    assign in_func = s_axis_tuser[0];
    assign in_a    = s_axis_tdata[9:0];
    assign in_b    = s_axis_tdata[19:10];
    assign add_ok  = (in_a != '0) && (32'(in_a) < MAX_NODES);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // saturating depth of a new child, parent depth on port a
    assign dw_data = (du == bllca_pkg::DEPTH_MAX) ? du : du + DPW'(1);

    // depth compared against: live read while ordering, stored value while lifting
    assign dv_cmp = (state_reg == S_SWAP) ? dv : dv_reg;

    // Tables are addressed with the next walker values, so their registered
    // outputs always belong to the current u_reg / v_reg / lvl_reg.
    bllca_ram #(
        .AW    (JAW),
        .WIDTH (NW)
    ) u_jump_ram (
        .clk       (clk),
        .wr_en     (jw_en),
        .wr_addr   ({x_reg, jw_lvl}),
        .wr_data   (jw_data),
        .rd_addr_a ({u_next, lvl_next}),
        .rd_zero_a (u_next == '0),
        .rd_addr_b ({v_next, lvl_next}),
        .rd_zero_b (v_next == '0),
        .rd_data_a (ju),
        .rd_data_b (jv)
    );

    bllca_ram #(
        .AW    (IDX_W),
        .WIDTH (DPW)
    ) u_depth_ram (
        .clk       (clk),
        .wr_en     (dw_en),
        .wr_addr   (x_reg),
        .wr_data   (dw_data),
        .rd_addr_a (u_next),
        .rd_zero_a (u_next == '0),
        .rd_addr_b (v_next),
        .rd_zero_b (v_next == '0),
        .rd_data_a (du),
        .rd_data_b (dv)
    );

    bllca_step_unit u_step (
        .ctl (step_ctl),
        .du  (du),
        .dv  (dv_cmp),
        .ju  (ju),
        .jv  (jv),
        .hit (step_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        x_next         = x_reg;
        lvl_next       = lvl_reg;
        dv_next        = dv_reg;
        eq_next        = eq_reg;
        jw_en          = 1'b0;
        dw_en          = 1'b0;
        jw_lvl         = lvl_reg;
        jw_data        = ju;
        res_load       = 1'b0;
        res_data       = ju;
        lift_u         = u_reg;
        step_ctl.mode  = bllca_pkg::STEP_LIFT;
        step_ctl.shift = SW'(lvl_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_func)
                    begin
                        u_next     = clamp_node(in_a);
                        v_next     = clamp_node(in_b);
                        lvl_next   = LVL_TOP;
                        state_next = S_SWAP;
                    end
                    else if (add_ok)
                    begin
                        x_next     = IDX_W'(in_a);
                        u_next     = clamp_node(in_b);
                        lvl_next   = '0;
                        state_next = S_ADD0;
                    end
                end
            end
            S_ADD0:
            begin
                // level 0 is the parent; depth from the parent's depth
                dw_en    = 1'b1;
                jw_en    = 1'b1;
                jw_lvl   = '0;
                jw_data  = NW'(u_reg);
                lvl_next = '0;
                state_next = (LVL_TOP == '0) ? S_IDLE : S_FILL;
            end
            S_FILL:
            begin
                // level k+1 of x is level k of the current mid node
                jw_en    = 1'b1;
                jw_lvl   = lvl_reg + LVL_W'(1);
                jw_data  = ju;
                u_next   = clamp_node(ju);
                lvl_next = lvl_reg + LVL_W'(1);
                if ((lvl_reg + LVL_W'(1)) == LVL_TOP)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWAP:
            begin
                step_ctl.mode = bllca_pkg::STEP_ORDER;
                if (step_hit)
                begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    dv_next = du;
                end
                else
                begin
                    dv_next = dv;
                end
                lvl_next   = LVL_TOP;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                step_ctl.mode = bllca_pkg::STEP_LIFT;
                if (step_hit)
                begin
                    lift_u = clamp_node(ju);
                end
                u_next = lift_u;
                if (lvl_reg == '0)
                begin
                    if (lift_u == v_reg)
                    begin
                        eq_next    = 1'b1;
                        lvl_next   = '0;
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        eq_next    = 1'b0;
                        lvl_next   = LVL_TOP;
                        state_next = S_CLIMB;
                    end
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_CLIMB:
            begin
                step_ctl.mode = bllca_pkg::STEP_CLIMB;
                if (step_hit)
                begin
                    u_next = clamp_node(ju);
                    v_next = clamp_node(jv);
                end
                if (lvl_reg == '0)
                begin
                    lvl_next   = '0;
                    state_next = S_FINAL;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_FINAL:
            begin
                // jump data here is level 0 of u, the parent of u, which after the climb is the meeting point
                res_data = eq_reg ? NW'(u_reg) : ju;
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        x_reg   <= x_next;
        lvl_reg <= lvl_next;
        dv_reg  <= dv_next;
        eq_reg  <= eq_next;
        if (res_load)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(out_data_reg);

    `BL_ASSERT(a_load_into_free, res_load |-> (!out_valid_reg || m_axis_tready), "result overwrote a waiting beat")
    `BL_ASSERT(a_write_only_add, (jw_en || dw_en) |-> (state_reg == S_ADD0 || state_reg == S_FILL), "table write outside an add")
    `BL_ASSERT(a_level_range, (state_reg == S_FILL || state_reg == S_LIFT || state_reg == S_CLIMB) |-> (32'(lvl_reg) < JUMP_LEVELS), "jump level out of range")
    `BL_ASSERT_NEXT(a_add_silent, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]), !res_load, "add produced a result")

endmodule

// ===== tb/lca_tb_pkg.sv =====
// Operation codes shared by the LCA engine testbench files.
`timescale 1ns / 1ps

package lca_tb_pkg;

    // tuser of an s_axis beat
    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

// ===== tb/lca_answer_check.sv =====
// Watches both LCA engine channels, predicts each answer and compares it.
`timescale 1ns / 1ps

module lca_answer_check #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // node_a, node_b, zero padding
    input  logic [bllca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ancestor, zero padding
    input  logic [bllca_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                                fail_count,
    output int                                awaiting
);

    localparam int NODE_W  = bllca_pkg::NODE_W;
    localparam int DEPTH_W = bllca_pkg::DEPTH_W;

    // Shadow tree: ancestor 2^i up, and depth, per node.
    logic [NODE_W-1:0]  up_tbl    [MAX_NODES][JUMP_LEVELS];
    logic [DEPTH_W-1:0] depth_tbl [MAX_NODES];

    logic [NODE_W-1:0]  answers_q [$];
    logic [NODE_W-1:0]  want;
    logic [NODE_W-1:0]  got;
    int                 node_a;
    int                 node_b;
    int                 fails   = 0;
    int                 pending = 0;

    assign fail_count = fails;
    assign awaiting   = pending;

    initial
    begin
        for (int n = 0; n < MAX_NODES; n++)
        begin
            depth_tbl[n] = '0;
            for (int l = 0; l < JUMP_LEVELS; l++)
                up_tbl[n][l] = '0;
        end
    end

    function automatic int clamp_id(int n);
        return (n < MAX_NODES) ? n : 0;
    endfunction

    // Node x hangs under p: depth one more (saturating), jump row built from p upwards.
    function automatic void hang_under(int x, int p);
        int d;
        int mid;
        d = int'(depth_tbl[p]) + 1;
        if (d > int'(bllca_pkg::DEPTH_MAX))
            d = int'(bllca_pkg::DEPTH_MAX);
        up_tbl[x][0] = NODE_W'(p);
        depth_tbl[x] = DEPTH_W'(d);
        for (int l = 1; l < JUMP_LEVELS; l++)
        begin
            mid          = clamp_id(int'(up_tbl[x][l-1]));
            up_tbl[x][l] = up_tbl[mid][l-1];
        end
    endfunction

    function automatic int meeting_point(int u, int v);
        int t;
        if (depth_tbl[u] < depth_tbl[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        // bring the deeper node up to the other's depth
        for (int l = JUMP_LEVELS - 1; l >= 0; l--)
            if (int'(depth_tbl[u]) >= int'(depth_tbl[v]) + (1 << l))
                u = clamp_id(int'(up_tbl[u][l]));
        if (u == v)
            return u;
        // climb both while the ancestors still differ
        for (int l = JUMP_LEVELS - 1; l >= 0; l--)
            if (up_tbl[u][l] != up_tbl[v][l])
            begin
                u = clamp_id(int'(up_tbl[u][l]));
                v = clamp_id(int'(up_tbl[v][l]));
            end
        return int'(up_tbl[u][0]);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result beat first: it can only answer an earlier query
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[NODE_W-1:0];
                if (answers_q.size() == 0)
                begin
                    $error("ancestor: beat %0d with no query waiting", got);
                    fails++;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (got !== want)
                    begin
                        $error("ancestor: expected %0d, actual %0d", want, got);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                node_a = int'(s_axis_tdata[NODE_W-1:0]);
                node_b = int'(s_axis_tdata[2*NODE_W-1:NODE_W]);
                if (s_axis_tuser == lca_tb_pkg::FUNC_QUERY)
                    answers_q = {answers_q, NODE_W'(meeting_point(clamp_id(node_a),
                                                                  clamp_id(node_b)))};
                else if (node_a != 0 && node_a < MAX_NODES)
                    hang_under(node_a, clamp_id(node_b));
            end
            pending <= answers_q.size();
        end
    end

endmodule

// ===== tb/tb_binary_lifting_lca_engine_core.sv =====
// Stimulus and verdict for the binary-lifting LCA engine.
`timescale 1ns / 1ps

module tb_binary_lifting_lca_engine_core;

    localparam int NODE_W           = bllca_pkg::NODE_W;
    localparam int IN_TDATA_W       = bllca_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W      = bllca_pkg::OUT_TDATA_W;
    localparam int MAX_NODES        = 1024;
    localparam int JUMP_LEVELS      = 11;
    localparam int RANDOM_PER_PHASE = 100;   // four idling phases, ~400 beats
    localparam int PRESSURE_QUERIES = 24;
    localparam int HOLD_CYCLES      = 400;   // long m_axis hold-off
    localparam int CHAIN_ADDS       = 40;    // re-adds low nodes as one chain
    localparam int TAIL_CYCLES      = 2 * JUMP_LEVELS + 12;
    localparam int STALL_LIMIT      = 5000;  // cycles without any beat

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // node_a [9:0], node_b [19:10], zero [23:20]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // func
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // ancestor [9:0], zero [15:10]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int awaiting;

    // Idling knobs, percent of cycles.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Hold-off handshake between stimulus and the receiver process.
    int holds_asked = 0;
    int holds_done  = 0;

    // Nodes the engine has seen added; only these (and node 0) may be referenced.
    bit known [MAX_NODES];
    int known_list [$];
    int tip = 0;

    int quiet = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    binary_lifting_lca_engine_core #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lca_answer_check #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) answer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    // Watchdog: any beat on either side counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("tb_binary_lifting_lca_engine_core: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the
    // result register fills and the engine backs up onto s_axis.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                repeat (HOLD_CYCLES)
                begin
                    m_axis_tready = 1'b0;
                    @(negedge clk);
                end
            end
            m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Entered and left on a falling edge; holds the beat until taken.
    task automatic offer(input lca_tb_pkg::func_t func, input int a, input int b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = IN_TDATA_W'({NODE_W'(b), NODE_W'(a)});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_item(input int x, input int p);
        offer(lca_tb_pkg::FUNC_ADD, x, p);
        if (x != 0)
        begin
            if (!known[x])
            begin
                known[x]   = 1'b1;
                known_list = {known_list, x};
            end
            tip = x;
        end
    endtask

    task automatic ask(input int u, input int v);
        offer(lca_tb_pkg::FUNC_QUERY, u, v);
    endtask

    // An added node, or now and then the sentinel.
    function automatic int pick_known();
        if (known_list.size() == 0 || $urandom_range(99) < 8)
            return 0;
        return known_list[$urandom_range(known_list.size() - 1)];
    endfunction

    // Mostly tree building and queries; some adds of node 0, which the engine drops.
    task automatic random_item(output bit counted);
        int r;
        int sel;
        int x;
        int p;
        r       = $urandom_range(99);
        counted = 1'b1;
        if (r < 8)
        begin
            add_item(0, pick_known());
            counted = 1'b0;
        end
        else if (r < 50 || known_list.size() == 0)
        begin
            x   = $urandom_range(MAX_NODES - 1, 1);
            sel = $urandom_range(99);
            if (sel < 12)
                p = 0;
            else if (sel < 60 && tip != 0)
                p = tip;            // grows chains, so the lift steps get exercised
            else
                p = pick_known();
            add_item(x, p);
        end
        else
            ask(pick_known(), pick_known());
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int n;
        bit counted;
        n              = 0;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (n < RANDOM_PER_PHASE)
        begin
            random_item(counted);
            n += counted;
        end
    endtask

    initial
    begin
        int prev;
        int x;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lca_tb_pkg::FUNC_ADD;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sentinel, extremes of node numbers, roots, re-add, ignored adds.
        add_item(0, 0);
        add_item(1, 0);
        add_item(1023, 1);
        add_item(512, 1023);
        add_item(2, 1);
        ask(0, 0);
        ask(1, 1);
        ask(1023, 512);
        ask(512, 2);
        ask(0, 1023);
        ask(1023, 1023);
        add_item(3, 0);
        ask(3, 512);
        add_item(512, 3);
        ask(512, 1023);
        ask(512, 3);
        add_item(0, 1023);
        add_item(1022, 512);
        ask(1022, 1023);

        random_phase(0, 0);
        random_phase(52, 0);
        random_phase(0, 52);
        random_phase(31, 31);

        // Pressure: receiver holds off while queries keep coming.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holds_asked++;
        repeat (PRESSURE_QUERIES)
            ask(pick_known(), pick_known());

        // One chain over the low node numbers, each re-added under the one
        // before; spot queries along the way.
        prev = 0;
        for (int i = 0; i < CHAIN_ADDS; i++)
        begin
            x = (i % (MAX_NODES - 1)) + 1;
            add_item(x, prev);
            if (i % 13 == 12)
            begin
                ask(x, pick_known());
                ask(prev, x);
            end
            prev = x;
        end
        ask(prev, pick_known());

        s_axis_tvalid = 1'b0;
        while (awaiting != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && awaiting == 0)
            $display("tb_binary_lifting_lca_engine_core: clean");
        else
            $display("tb_binary_lifting_lca_engine_core: errors");
        $finish;
    end

endmodule
